// ===== rtl/dtd_pkg.sv =====
package dtd_pkg;

    localparam logic [15:0] MaxLen     = 16'd4096;
    localparam logic [4:0]  MantDigits = 5'd18;
    localparam logic [8:0]  ExpLimit   = 9'd511;
    localparam logic [13:0] ExpAccMax  = 14'd16383;
    localparam logic [3:0]  PowCount   = 4'd9;

    localparam logic [63:0] OneBits    = 64'h3FF0000000000000;
    localparam logic [63:0] NanBits    = 64'h7FF8000000000000;
    localparam logic [63:0] DefNanBits = 64'hFFF8000000000000;
    localparam logic [63:0] InfBits    = 64'h7FF0000000000000;
    localparam logic [63:0] NegInfBits = 64'hFFF0000000000000;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_string;
    } item_t;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        parse_error;
    } result_t;

    typedef enum logic [3:0] {
        FIN_ERR = 4'b0001,
        FIN_NAN = 4'b0010,
        FIN_INF = 4'b0100,
        FIN_NUM = 4'b1000
    } fin_kind_t;

    typedef struct packed {
        fin_kind_t   kind;
        logic        negative;
        logic [59:0] mant;
        logic [4:0]  kept;
        logic [15:0] dbp;
        logic [13:0] exp_acc;
        logic        exp_neg;
    } fin_t;

    typedef enum logic [2:0] {
        OP_CVT = 3'b001,
        OP_MUL = 3'b010,
        OP_DIV = 3'b100
    } fop_t;

    typedef struct packed {
        logic        go;
        fop_t        op;
        logic [63:0] a;
        logic [63:0] b;
    } freq_t;

    typedef struct packed {
        logic        done;
        logic [63:0] bits;
    } fresp_t;

    // 10^(2^idx) as rounded doubles
    function automatic logic [63:0] pow_bits(input logic [3:0] idx);
        logic [63:0] v;
        case (idx)
            4'd0:    v = 64'h4024000000000000;
            4'd1:    v = 64'h4059000000000000;
            4'd2:    v = 64'h40C3880000000000;
            4'd3:    v = 64'h4197D78400000000;
            4'd4:    v = 64'h4341C37937E08000;
            4'd5:    v = 64'h4693B8B5B5056E17;
            4'd6:    v = 64'h4D384F03E93FF9F5;
            4'd7:    v = 64'h5A827748F9301D32;
            4'd8:    v = 64'h75154FDD7F73BF3C;
            default: v = OneBits;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/dtd_parse.sv =====
module dtd_parse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  dtd_pkg::item_t item,
    output dtd_pkg::fin_t  fin,
    output logic           fin_valid
);

    typedef enum logic [6:0] {
        P_START    = 7'b0000001,
        P_SIGNED   = 7'b0000010,
        P_MANT     = 7'b0000100,
        P_EXP_MARK = 7'b0001000,
        P_EXP_SIGN = 7'b0010000,
        P_EXP_DIG  = 7'b0100000,
        P_WORD     = 7'b1000000
    } phase_t;

    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChPoint = 8'h2E;
    localparam logic [7:0] ChE     = 8'h65;
    localparam logic [7:0] ChN     = 8'h6E;
    localparam logic [7:0] ChI     = 8'h69;
    localparam logic [7:0] ChA     = 8'h61;
    localparam logic [7:0] ChF     = 8'h66;

    localparam logic [2:0] WmN   = 3'd1;
    localparam logic [2:0] WmNa  = 3'd2;
    localparam logic [2:0] WmNan = 3'd3;
    localparam logic [2:0] WmI   = 3'd4;
    localparam logic [2:0] WmIn  = 3'd5;
    localparam logic [2:0] WmInf = 3'd6;

    phase_t        phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [59:0]   mant_reg, mant_next;
    logic [4:0]    kept_reg, kept_next;
    logic [15:0]   dbp_reg, dbp_next;
    logic          point_reg, point_next;
    logic [13:0]   exp_reg, exp_next;
    logic          eneg_reg, eneg_next;
    logic [15:0]   count_reg, count_next;
    logic [2:0]    word_reg, word_next;
    logic          err_reg, err_next;
    dtd_pkg::fin_t fin_reg, fin_next;
    logic          fin_valid_reg;

    logic [7:0]  c;
    logic [7:0]  lc;
    logic        is_dig;
    logic [3:0]  dig;
    logic        in_mant;
    logic        in_exp;
    logic [17:0] exp_wide;

    always_comb
    begin
        c        = item.char_code;
        lc       = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        is_dig   = (c >= 8'h30 && c <= 8'h39);
        dig      = c[3:0];
        in_mant  = 1'b0;
        in_exp   = 1'b0;
        exp_wide = ({4'b0, exp_reg} << 3) + ({4'b0, exp_reg} << 1) + {14'b0, dig};

        phase_next = phase_reg;
        neg_next   = neg_reg;
        mant_next  = mant_reg;
        kept_next  = kept_reg;
        dbp_next   = dbp_reg;
        point_next = point_reg;
        exp_next   = exp_reg;
        eneg_next  = eneg_reg;
        word_next  = word_reg;
        count_next = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
        err_next   = err_reg | (count_next > dtd_pkg::MaxLen);

        if (!err_next)
        begin
            case (phase_reg)
                P_START:
                begin
                    if (c == ChMinus)
                    begin
                        neg_next   = 1'b1;
                        phase_next = P_SIGNED;
                    end
                    else if (c == ChPlus)
                    begin
                        phase_next = P_SIGNED;
                    end
                    else if (lc == ChN)
                    begin
                        phase_next = P_WORD;
                        word_next  = WmN;
                    end
                    else if (lc == ChI)
                    begin
                        phase_next = P_WORD;
                        word_next  = WmI;
                    end
                    else
                    begin
                        in_mant = 1'b1;
                    end
                end
                P_SIGNED:
                begin
                    if (lc == ChN)
                    begin
                        phase_next = P_WORD;
                        word_next  = WmN;
                    end
                    else if (lc == ChI)
                    begin
                        phase_next = P_WORD;
                        word_next  = WmI;
                    end
                    else
                    begin
                        in_mant = 1'b1;
                    end
                end
                P_MANT:
                begin
                    in_mant = 1'b1;
                end
                P_EXP_MARK:
                begin
                    if (c == ChMinus)
                    begin
                        eneg_next  = 1'b1;
                        phase_next = P_EXP_SIGN;
                    end
                    else if (c == ChPlus)
                    begin
                        phase_next = P_EXP_SIGN;
                    end
                    else
                    begin
                        in_exp = 1'b1;
                    end
                end
                P_EXP_SIGN, P_EXP_DIG:
                begin
                    in_exp = 1'b1;
                end
                P_WORD:
                begin
                    if (word_reg == WmN && lc == ChA)
                        word_next = WmNa;
                    else if (word_reg == WmNa && lc == ChN)
                        word_next = WmNan;
                    else if (word_reg == WmI && lc == ChN)
                        word_next = WmIn;
                    else if (word_reg == WmIn && lc == ChF)
                        word_next = WmInf;
                    else
                        err_next = 1'b1;
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase

            if (in_mant)
            begin
                phase_next = P_MANT;
                if (is_dig)
                begin
                    if (kept_reg < dtd_pkg::MantDigits)
                    begin
                        mant_next = {mant_reg[56:0], 3'b0} + {mant_reg[58:0], 1'b0}
                                  + {56'b0, dig};
                        kept_next = kept_reg + 5'd1;
                    end
                    if (!point_reg && dbp_reg != 16'hFFFF)
                        dbp_next = dbp_reg + 16'd1;
                end
                else if (c == ChPoint && !point_reg)
                begin
                    point_next = 1'b1;
                end
                else if (lc == ChE && kept_reg != 5'd0)
                begin
                    phase_next = P_EXP_MARK;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end

            if (in_exp)
            begin
                if (is_dig)
                begin
                    exp_next   = (exp_wide > {4'b0, dtd_pkg::ExpAccMax}) ?
                                 dtd_pkg::ExpAccMax : exp_wide[13:0];
                    phase_next = P_EXP_DIG;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end

        fin_next          = '0;
        fin_next.kind     = dtd_pkg::FIN_ERR;
        fin_next.negative = neg_next;
        fin_next.mant     = mant_next;
        fin_next.kept     = kept_next;
        fin_next.dbp      = dbp_next;
        fin_next.exp_acc  = exp_next;
        fin_next.exp_neg  = eneg_next;
        if (item.empty_string || err_next)
            fin_next.kind = dtd_pkg::FIN_ERR;
        else if (phase_next == P_WORD)
        begin
            if (word_next == WmNan)
                fin_next.kind = dtd_pkg::FIN_NAN;
            else if (word_next == WmInf)
                fin_next.kind = dtd_pkg::FIN_INF;
            else
                fin_next.kind = dtd_pkg::FIN_ERR;
        end
        else if ((phase_next == P_MANT && kept_next != 5'd0) || phase_next == P_EXP_DIG)
            fin_next.kind = dtd_pkg::FIN_NUM;
        else
            fin_next.kind = dtd_pkg::FIN_ERR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_START;
            neg_reg       <= 1'b0;
            mant_reg      <= '0;
            kept_reg      <= '0;
            dbp_reg       <= '0;
            point_reg     <= 1'b0;
            exp_reg       <= '0;
            eneg_reg      <= 1'b0;
            count_reg     <= '0;
            word_reg      <= '0;
            err_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= accept & item.last_char;
            if (accept)
            begin
                if (item.last_char)
                begin
                    // string done: back to start of string
                    phase_reg <= P_START;
                    neg_reg   <= 1'b0;
                    mant_reg  <= '0;
                    kept_reg  <= '0;
                    dbp_reg   <= '0;
                    point_reg <= 1'b0;
                    exp_reg   <= '0;
                    eneg_reg  <= 1'b0;
                    count_reg <= '0;
                    word_reg  <= '0;
                    err_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    mant_reg  <= mant_next;
                    kept_reg  <= kept_next;
                    dbp_reg   <= dbp_next;
                    point_reg <= point_next;
                    exp_reg   <= exp_next;
                    eneg_reg  <= eneg_next;
                    count_reg <= count_next;
                    word_reg  <= word_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.last_char)
            fin_reg <= fin_next;
    end

    assign fin       = fin_reg;
    assign fin_valid = fin_valid_reg;

endmodule

// ===== rtl/dtd_fpu.sv =====
module dtd_fpu (
    input  logic            clk,
    input  logic            rst_n,
    input  dtd_pkg::freq_t  req,
    output dtd_pkg::fresp_t resp
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_LOOP  = 3'b010,
        F_ROUND = 3'b100
    } fstate_t;

    fstate_t             state_reg;
    dtd_pkg::fop_t       op_reg;
    logic [105:0]        acc_reg;
    logic [52:0]         ma_reg;
    logic [52:0]         mb_reg;
    logic [53:0]         rem_reg;
    logic signed [12:0]  exp_reg;
    logic [5:0]          cnt_reg;
    logic                done_reg;
    logic [63:0]         bits_reg;

    logic [10:0]        fa, fb;
    logic [52:0]        sa, sb;
    logic               a_zero, b_zero, a_inf, b_inf;
    logic signed [12:0] ea, eb;
    logic               ge;
    logic [53:0]        diff;
    logic [55:0]        rsig;
    logic               rsticky;
    logic signed [12:0] rexp;

    // round to nearest even, with gradual underflow and overflow to infinity
    function automatic logic [63:0] round_pack(input logic [55:0] sig, input logic sticky,
                                               input logic signed [12:0] e);
        logic signed [12:0] biased;
        logic [12:0]        k;
        logic [5:0]         sh;
        logic [111:0]       wide;
        logic [55:0]        s;
        logic               st;
        logic [10:0]        field;
        logic [62:0]        packed_v;
        logic               up;
        logic [63:0]        res;
        biased = e + 13'sd1023;
        k      = 13'(13'sd1 - biased);
        sh     = (k > 13'd56) ? 6'd63 : k[5:0];
        wide   = {sig, 56'b0} >> sh;
        if (biased <= 13'sd0)
        begin
            s     = wide[111:56];
            st    = sticky | (|wide[55:0]);
            field = 11'd0;
        end
        else
        begin
            s     = sig;
            st    = sticky;
            field = biased[10:0];
        end
        packed_v = {field, s[54:3]};
        up       = s[2] & (s[1] | s[0] | st | s[3]);
        if (biased >= 13'sd2047)
            res = dtd_pkg::InfBits;
        else
            res = {1'b0, packed_v + {62'b0, up}};
        return res;
    endfunction

    always_comb
    begin
        fa     = req.a[62:52];
        fb     = req.b[62:52];
        sa     = {1'b1, req.a[51:0]};
        sb     = {1'b1, req.b[51:0]};
        a_zero = (fa == 11'd0);
        b_zero = (fb == 11'd0);
        a_inf  = (fa == 11'h7FF);
        b_inf  = (fb == 11'h7FF);
        ea     = $signed({2'b0, fa}) - 13'sd1023;
        eb     = $signed({2'b0, fb}) - 13'sd1023;

        ge   = rem_reg >= {1'b0, ma_reg};
        diff = ge ? rem_reg - {1'b0, ma_reg} : rem_reg;

        rsig    = acc_reg[59:4];
        rsticky = |acc_reg[3:0];
        rexp    = exp_reg;
        case (op_reg)
            dtd_pkg::OP_CVT:
            begin
                rsig    = acc_reg[59:4];
                rsticky = |acc_reg[3:0];
                rexp    = exp_reg;
            end
            dtd_pkg::OP_MUL:
            begin
                if (acc_reg[105])
                begin
                    rsig    = acc_reg[105:50];
                    rsticky = |acc_reg[49:0];
                    rexp    = exp_reg + 13'sd1;
                end
                else
                begin
                    rsig    = acc_reg[104:49];
                    rsticky = |acc_reg[48:0];
                    rexp    = exp_reg;
                end
            end
            dtd_pkg::OP_DIV:
            begin
                if (acc_reg[56])
                begin
                    rsig    = acc_reg[56:1];
                    rsticky = acc_reg[0] | (rem_reg != 54'd0);
                    rexp    = exp_reg;
                end
                else
                begin
                    rsig    = acc_reg[55:0];
                    rsticky = (rem_reg != 54'd0);
                    rexp    = exp_reg - 13'sd1;
                end
            end
            default:
            begin
                rsig    = acc_reg[59:4];
                rsticky = |acc_reg[3:0];
                rexp    = exp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                F_IDLE:
                begin
                    if (req.go)
                    begin
                        case (req.op)
                            dtd_pkg::OP_CVT:
                                if (req.a[59:0] == 60'd0)
                                    done_reg <= 1'b1;
                                else
                                    state_reg <= F_LOOP;
                            dtd_pkg::OP_MUL:
                                if (a_inf || b_inf || a_zero || b_zero)
                                    done_reg <= 1'b1;
                                else
                                    state_reg <= F_LOOP;
                            dtd_pkg::OP_DIV:
                                if (a_zero || b_inf)
                                    done_reg <= 1'b1;
                                else
                                    state_reg <= F_LOOP;
                            default:
                                done_reg <= 1'b1;
                        endcase
                    end
                end
                F_LOOP:
                begin
                    if (op_reg == dtd_pkg::OP_CVT)
                    begin
                        if (acc_reg[59])
                            state_reg <= F_ROUND;
                    end
                    else if (cnt_reg == 6'd1)
                    begin
                        state_reg <= F_ROUND;
                    end
                end
                F_ROUND:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (req.go)
                begin
                    op_reg <= req.op;
                    case (req.op)
                        dtd_pkg::OP_CVT:
                        begin
                            bits_reg <= 64'd0;
                            acc_reg  <= {46'b0, req.a[59:0]};
                            exp_reg  <= 13'sd59;
                        end
                        dtd_pkg::OP_MUL:
                        begin
                            if (a_inf || b_inf)
                                bits_reg <= (a_zero || b_zero) ? dtd_pkg::DefNanBits
                                                               : dtd_pkg::InfBits;
                            else
                                bits_reg <= 64'd0;
                            acc_reg <= '0;
                            ma_reg  <= sa;
                            mb_reg  <= sb;
                            exp_reg <= ea + eb;
                            cnt_reg <= 6'd53;
                        end
                        dtd_pkg::OP_DIV:
                        begin
                            bits_reg <= 64'd0;
                            acc_reg  <= '0;
                            rem_reg  <= {1'b0, sa};
                            ma_reg   <= sb;
                            exp_reg  <= ea - eb;
                            cnt_reg  <= 6'd57;
                        end
                        default:
                        begin
                            bits_reg <= 64'd0;
                        end
                    endcase
                end
            end
            F_LOOP:
            begin
                case (op_reg)
                    dtd_pkg::OP_CVT:
                    begin
                        // normalize one bit a cycle until the top bit is set
                        if (!acc_reg[59])
                        begin
                            acc_reg <= {acc_reg[104:0], 1'b0};
                            exp_reg <= exp_reg - 13'sd1;
                        end
                    end
                    dtd_pkg::OP_MUL:
                    begin
                        acc_reg <= {acc_reg[104:0], 1'b0}
                                 + (mb_reg[52] ? {53'b0, ma_reg} : 106'd0);
                        mb_reg  <= {mb_reg[51:0], 1'b0};
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                    dtd_pkg::OP_DIV:
                    begin
                        acc_reg <= {acc_reg[104:0], ge};
                        rem_reg <= {diff[52:0], 1'b0};
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                    default:
                    begin
                        cnt_reg <= cnt_reg;
                    end
                endcase
            end
            F_ROUND:
            begin
                bits_reg <= round_pack(rsig, rsticky, rexp);
            end
            default:
            begin
                bits_reg <= bits_reg;
            end
        endcase
    end

    assign resp.done = done_reg;
    assign resp.bits = bits_reg;

endmodule

// ===== rtl/decimal_text_to_double.sv =====
// parsing takes one character per cycle; busy stays low while a string streams in
// error, nan and inf results pass the parser's fin register, then the result register
// numbers: convert the digits, one multiply per set bit of the clamped exponent, then the
// final multiply or divide, all in one bit-serial multiply/divide unit; busy is high from
// the last character to the result
// rst_n is asynchronous, active low, and returns the parser to start of string
module decimal_text_to_double (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  dtd_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output dtd_pkg::result_t result
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CVT   = 5'b00010,
        S_SCALE = 5'b00100,
        S_SWAIT = 5'b01000,
        S_APPLY = 5'b10000
    } seq_t;

    seq_t             state_reg, state_next;
    logic [3:0]       idx_reg, idx_next;
    logic [8:0]       eabs_reg, eabs_next;
    logic             down_reg, down_next;
    logic             neg_reg, neg_next;
    logic [63:0]      frac_reg, frac_next;
    logic [63:0]      scale_reg, scale_next;
    logic             done_reg, done_next;
    dtd_pkg::result_t result_reg, result_next;

    dtd_pkg::fin_t    fin;
    logic             fin_valid;
    dtd_pkg::freq_t   freq;
    dtd_pkg::fresp_t  fresp;
    logic             accept;

    logic signed [17:0] e0, e1;
    logic [17:0]        emag;

    assign busy   = (state_reg != S_IDLE) | fin_valid;
    assign accept = start & ~busy;

    dtd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .fin       (fin),
        .fin_valid (fin_valid)
    );

    dtd_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (freq),
        .resp  (fresp)
    );

    always_comb
    begin
        e0   = $signed({2'b0, fin.dbp}) - $signed({13'b0, fin.kept});
        e1   = fin.exp_neg ? e0 - $signed({4'b0, fin.exp_acc})
                           : e0 + $signed({4'b0, fin.exp_acc});
        emag = (e1 < 18'sd0) ? 18'(-e1) : 18'(e1);

        state_next  = state_reg;
        idx_next    = idx_reg;
        eabs_next   = eabs_reg;
        down_next   = down_reg;
        neg_next    = neg_reg;
        frac_next   = frac_reg;
        scale_next  = scale_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        freq        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (fin_valid)
                begin
                    case (fin.kind)
                        dtd_pkg::FIN_NUM:
                        begin
                            down_next  = (e1 < 18'sd0);
                            eabs_next  = (emag > {9'b0, dtd_pkg::ExpLimit}) ?
                                         dtd_pkg::ExpLimit : emag[8:0];
                            neg_next   = fin.negative;
                            freq.go    = 1'b1;
                            freq.op    = dtd_pkg::OP_CVT;
                            freq.a     = {4'b0, fin.mant};
                            state_next = S_CVT;
                        end
                        dtd_pkg::FIN_NAN:
                        begin
                            result_next = {dtd_pkg::NanBits, 1'b0};
                            done_next   = 1'b1;
                        end
                        dtd_pkg::FIN_INF:
                        begin
                            result_next = {fin.negative ? dtd_pkg::NegInfBits
                                                        : dtd_pkg::InfBits, 1'b0};
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            result_next = {64'd0, 1'b1};
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_CVT:
            begin
                if (fresp.done)
                begin
                    frac_next  = fresp.bits;
                    scale_next = dtd_pkg::OneBits;
                    idx_next   = 4'd0;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                // walk the exponent bits lowest first
                if (idx_reg == dtd_pkg::PowCount)
                begin
                    freq.go    = 1'b1;
                    freq.op    = down_reg ? dtd_pkg::OP_DIV : dtd_pkg::OP_MUL;
                    freq.a     = frac_reg;
                    freq.b     = scale_reg;
                    state_next = S_APPLY;
                end
                else if (eabs_reg[idx_reg])
                begin
                    freq.go    = 1'b1;
                    freq.op    = dtd_pkg::OP_MUL;
                    freq.a     = scale_reg;
                    freq.b     = dtd_pkg::pow_bits(idx_reg);
                    state_next = S_SWAIT;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            S_SWAIT:
            begin
                if (fresp.done)
                begin
                    scale_next = fresp.bits;
                    idx_next   = idx_reg + 4'd1;
                    state_next = S_SCALE;
                end
            end
            S_APPLY:
            begin
                if (fresp.done)
                begin
                    result_next = {fresp.bits ^ {neg_reg, 63'b0}, 1'b0};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        eabs_reg   <= eabs_next;
        down_reg   <= down_next;
        neg_reg    <= neg_next;
        frac_reg   <= frac_next;
        scale_reg  <= scale_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word strobed on two cycles in a row");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.last_char |=> busy)
        else $error("not busy after last character");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.parse_error |-> result.value_bits == 64'd0)
        else $error("error word carries nonzero value");

    a_fpu_owned: assert property (@(posedge clk) disable iff (!rst_n)
        fresp.done |-> state_reg != S_IDLE)
        else $error("arithmetic unit finished with no request pending");

endmodule
